// ===== sv/wsd_pkg.sv =====
package wsd_pkg;

    // opcode classes shown on the result channel
    localparam logic [2:0] OPC_CONT     = 3'd0;
    localparam logic [2:0] OPC_TEXT     = 3'd1;
    localparam logic [2:0] OPC_BINARY   = 3'd2;
    localparam logic [2:0] OPC_CLOSE    = 3'd3;
    localparam logic [2:0] OPC_PING     = 3'd4;
    localparam logic [2:0] OPC_PONG     = 3'd5;
    localparam logic [2:0] OPC_RESERVED = 3'd6;

    // raw opcodes of the first header byte
    localparam logic [3:0] RAW_CONT   = 4'h0;
    localparam logic [3:0] RAW_TEXT   = 4'h1;
    localparam logic [3:0] RAW_BINARY = 4'h2;
    localparam logic [3:0] RAW_CLOSE  = 4'h8;
    localparam logic [3:0] RAW_PING   = 4'h9;
    localparam logic [3:0] RAW_PONG   = 4'hA;

    // 7-bit length codes that select an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // extended length byte counts, minus one
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [1:0] KEY_LAST   = 2'd3;

    localparam int unsigned LEN_W = 64;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXT     = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } wsd_phase_t;

    // one result item
    typedef struct packed {
        logic             is_payload;
        logic [7:0]       data_out;
        logic             frame_done;
        logic             fin_flag;
        logic [2:0]       opcode_class;
        logic             masked;
        logic [LEN_W-1:0] payload_length;
    } wsd_item_t;

    function automatic logic [2:0] classify_opcode(input logic [3:0] op);
        logic [2:0] cls;
        unique case (op)
            RAW_CONT:   cls = OPC_CONT;
            RAW_TEXT:   cls = OPC_TEXT;
            RAW_BINARY: cls = OPC_BINARY;
            RAW_CLOSE:  cls = OPC_CLOSE;
            RAW_PING:   cls = OPC_PING;
            RAW_PONG:   cls = OPC_PONG;
            default:    cls = OPC_RESERVED;
        endcase
        return cls;
    endfunction

endpackage

// ===== sv/websocket_frame_deframer_unit.sv =====
// path: an s_ byte passes the input register, then the parser logic into the result
//   register, before it shows on m_
// throughput: one byte per cycle while m_ is not stalled, limited by the parser state update
// reset: aresetn low at a clock edge empties both registers and returns the parser
//   to the first header byte with all frame fields cleared
module websocket_frame_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] restart
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] data_out, [8] fin_flag, [11:9] opcode_class,
                                   // [12] masked, [76:13] payload_length, [79:77] zero
    output logic        m_tuser,   // [0] is_payload
    output logic        m_tlast    // frame_done
);
    import wsd_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;

    logic       out_free;   // result register can take a new item this cycle
    logic       step;       // the buffered byte moves through the parser
    logic       s_accept;

    wsd_item_t  parsed;
    wsd_item_t  result;

    assign out_free = !m_tvalid || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload holds while stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    // header decode, length gathering, key capture and unmasking
    wsd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .in_byte (in_byte_reg),
        .restart (in_restart_reg),
        .result  (parsed)
    );

    // result register, holds an item until m_tready takes it
    wsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .item_in  (parsed),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .item_out (result)
    );

    assign m_tdata = {3'b000, result.payload_length, result.masked, result.opcode_class,
                      result.fin_flag, result.data_out};
    assign m_tuser = result.is_payload;
    assign m_tlast = result.frame_done;

endmodule

// ===== sv/wsd_parser.sv =====
module wsd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        in_byte,
    input  logic              restart,
    output wsd_pkg::wsd_item_t result
);
    import wsd_pkg::*;

    wsd_phase_t       phase_reg, phase_next;
    logic             fin_reg, fin_next;
    logic [2:0]       opcode_reg, opcode_next;
    logic             mask_reg, mask_next;
    logic [LEN_W-1:0] full_length_reg, full_length_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [2:0]       step_cnt_reg, step_cnt_next;
    logic [3:0][7:0]  key_reg, key_next;

    always_comb begin
        logic       len_known;
        logic       len_mask;
        logic       len_zero;
        logic [7:0] key_byte;

        phase_next       = phase_reg;
        fin_next         = fin_reg;
        opcode_next      = opcode_reg;
        mask_next        = mask_reg;
        full_length_next = full_length_reg;
        count_next       = count_reg;
        step_cnt_next    = step_cnt_reg;
        key_next         = key_reg;
        len_known        = 1'b0;
        len_mask         = 1'b0;
        len_zero         = 1'b0;
        key_byte         = 8'd0;
        result           = '0;

        if (restart) begin
            phase_next = PH_HDR0;
        end else begin
            unique case (phase_reg)
                PH_HDR1: begin
                    mask_next  = in_byte[7];
                    count_next = '0;
                    if (in_byte[6:0] == LEN_EXT16) begin
                        full_length_next = '0;
                        step_cnt_next    = EXT16_LAST;
                        phase_next       = PH_EXT;
                    end else if (in_byte[6:0] == LEN_EXT64) begin
                        full_length_next = '0;
                        step_cnt_next    = EXT64_LAST;
                        phase_next       = PH_EXT;
                    end else begin
                        full_length_next = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
                        len_known        = 1'b1;
                        len_mask         = in_byte[7];
                        len_zero         = (in_byte[6:0] == 7'd0);
                    end
                end
                PH_EXT: begin
                    // big-endian: shift in one byte a cycle while step_en is high
                    full_length_next = {full_length_reg[LEN_W-9:0], in_byte};
                    if (step_cnt_reg == 3'd0) begin
                        len_known = 1'b1;
                        len_mask  = mask_reg;
                        len_zero  = (full_length_next == '0);
                    end else begin
                        step_cnt_next = step_cnt_reg - 3'd1;
                    end
                end
                PH_KEY: begin
                    key_next[step_cnt_reg[1:0]] = in_byte;
                    if (step_cnt_reg[1:0] == KEY_LAST) begin
                        if (full_length_reg == '0) begin
                            // zero-length masked frame ends on its last key byte
                            result.frame_done = 1'b1;
                            phase_next        = PH_HDR0;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end else begin
                        step_cnt_next = step_cnt_reg + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    key_byte          = mask_reg ? key_reg[count_reg[1:0]] : 8'd0;
                    result.is_payload = 1'b1;
                    result.data_out   = in_byte ^ key_byte;
                    count_next        = count_reg + {{(LEN_W-1){1'b0}}, 1'b1};
                    if (count_next == full_length_reg) begin
                        result.frame_done = 1'b1;
                        phase_next        = PH_HDR0;
                    end
                end
                default: begin
                    // first header byte
                    fin_next         = in_byte[7];
                    opcode_next      = classify_opcode(in_byte[3:0]);
                    mask_next        = 1'b0;
                    full_length_next = '0;
                    count_next       = '0;
                    phase_next       = PH_HDR1;
                end
            endcase

            if (len_known) begin
                step_cnt_next = 3'd0;
                if (len_mask) begin
                    phase_next = PH_KEY;
                end else if (len_zero) begin
                    result.frame_done = 1'b1;
                    phase_next        = PH_HDR0;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end

        result.fin_flag       = fin_next;
        result.opcode_class   = opcode_next;
        result.masked         = mask_next;
        result.payload_length = full_length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR0;
            fin_reg         <= 1'b0;
            opcode_reg      <= 3'd0;
            mask_reg        <= 1'b0;
            full_length_reg <= '0;
            count_reg       <= '0;
            step_cnt_reg    <= 3'd0;
            key_reg         <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            fin_reg         <= fin_next;
            opcode_reg      <= opcode_next;
            mask_reg        <= mask_next;
            full_length_reg <= full_length_next;
            count_reg       <= count_next;
            step_cnt_reg    <= step_cnt_next;
            key_reg         <= key_next;
        end
    end

endmodule

// ===== sv/wsd_out_stage.sv =====
module wsd_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  wsd_pkg::wsd_item_t item_in,
    input  logic               m_tready,
    output logic               m_tvalid,
    output wsd_pkg::wsd_item_t item_out
);
    import wsd_pkg::*;

    logic      valid_reg, valid_next;
    wsd_item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign item_out = item_reg;

endmodule

// ===== sv/wsd_checker.sv =====
module wsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // header, key and ignored bytes carry zero data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("non-payload byte with nonzero data");

    // a payload byte belongs to a frame of nonzero length
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[76:13] != 64'd0)
        else $error("payload byte in a zero-length frame");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (.*);
